[design/u8sd_pkg.sv]
// Shared types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8sd_pkg;

    localparam int UNIT_W   = 21;
    localparam int STATUS_W = 2;
    localparam int MAX_RES  = 3;

    localparam logic [STATUS_W-1:0] ST_UNIT      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_END_OK    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_END_STRAY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_END_TRUNC = 2'd3;

    localparam logic [0:0] REG_UTF16_OUTPUT = 1'b0;
    localparam logic [0:0] REG_SKIP_BOM     = 1'b1;

    localparam logic [7:0] BOM_B0 = 8'hEF;
    localparam logic [7:0] BOM_B1 = 8'hBB;
    localparam logic [7:0] BOM_B2 = 8'hBF;

    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

    typedef struct packed {
        logic [UNIT_W-1:0]   unit;
        logic [STATUS_W-1:0] status;
        logic                run_last;
    } result_t;

    // up to three results from one byte, filled from entry 0 upward
    typedef struct packed {
        logic [1:0]                count;
        result_t [MAX_RES-1:0]     items;
    } result_group_t;

endpackage

[design/u8sd_decode.sv]
// Decoder state, configuration registers and per-byte result generation.
`timescale 1ns / 1ps

module u8sd_decode (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [0:0]               cfg_index,
    input  logic [0:0]               cfg_data,
    input  logic                     take,
    input  logic [7:0]               data_byte,
    input  logic                     end_of_buffer,
    output u8sd_pkg::result_group_t  group
);

    logic                        utf16_reg;
    logic                        skip_bom_reg;
    logic [u8sd_pkg::UNIT_W-1:0] acc_reg,   acc_next;
    logic [1:0]                  cont_reg,  cont_next;
    logic                        fail_reg,  fail_next;
    logic                        start_reg, start_next;
    logic                        bom_reg,   bom_next;

    logic                        emit_v;
    logic [u8sd_pkg::UNIT_W-1:0] emit_cp;
    logic [u8sd_pkg::UNIT_W-1:0] acc_cat;
    logic                        bom_keep;
    logic [u8sd_pkg::UNIT_W-1:0] off;
    logic                        pair;
    logic [1:0]                  emit_n;
    logic [u8sd_pkg::STATUS_W-1:0] end_st;
    u8sd_pkg::result_t           r_a, r_b, r_end;

    always_comb
    begin
        acc_next   = acc_reg;
        cont_next  = cont_reg;
        fail_next  = fail_reg;
        start_next = 1'b0;
        bom_next   = bom_reg;
        emit_v     = 1'b0;
        emit_cp    = '0;
        acc_cat    = {acc_reg[u8sd_pkg::UNIT_W-7:0], data_byte[5:0]};
        bom_keep   = bom_reg && (data_byte == ((cont_reg == 2'd2) ? u8sd_pkg::BOM_B1
                                                                  : u8sd_pkg::BOM_B2));

        priority if (fail_reg)
        begin
            // failed buffer: byte dropped
        end
        else if (cont_reg != 2'd0)
        begin
            cont_next = cont_reg - 2'd1;
            emit_cp   = acc_cat;
            if (cont_reg == 2'd1)
            begin
                emit_v   = !bom_keep;
                bom_next = 1'b0;
                acc_next = '0;
            end
            else
            begin
                bom_next = bom_keep;
                acc_next = acc_cat;
            end
        end
        else if (data_byte[7] == 1'b0)
        begin
            emit_v  = 1'b1;
            emit_cp = {13'd0, data_byte};
        end
        else if (data_byte[7:6] == 2'b10)
        begin
            fail_next = 1'b1;
        end
        else if (data_byte[7:5] == 3'b110)
        begin
            acc_next  = {16'd0, data_byte[4:0]};
            cont_next = 2'd1;
        end
        else if (data_byte[7:4] == 4'b1110)
        begin
            acc_next  = {17'd0, data_byte[3:0]};
            cont_next = 2'd2;
            bom_next  = start_reg && skip_bom_reg && (data_byte == u8sd_pkg::BOM_B0);
        end
        else if (data_byte[7:3] == 5'b11110)
        begin
            acc_next  = {18'd0, data_byte[2:0]};
            cont_next = 2'd3;
        end
        else
        begin
            emit_v  = 1'b1;
            emit_cp = '0;
        end

        priority if (fail_next)
            end_st = u8sd_pkg::ST_END_STRAY;
        else if (cont_next != 2'd0)
            end_st = u8sd_pkg::ST_END_TRUNC;
        else
            end_st = u8sd_pkg::ST_END_OK;

        if (end_of_buffer)
        begin
            acc_next   = '0;
            cont_next  = 2'd0;
            fail_next  = 1'b0;
            start_next = 1'b1;
            bom_next   = 1'b0;
        end

        off  = emit_cp - 21'h10000;
        pair = utf16_reg && (emit_cp[20:16] != 5'd0);

        r_a = '{unit: emit_cp, status: u8sd_pkg::ST_UNIT, run_last: 1'b0};
        r_b = '{unit: '0, status: u8sd_pkg::ST_UNIT, run_last: 1'b0};
        if (pair)
        begin
            r_a.unit = {5'd0, u8sd_pkg::HI_SURR_BASE + {6'd0, off[19:10]}};
            r_b.unit = {5'd0, u8sd_pkg::LO_SURR_BASE + {6'd0, off[9:0]}};
        end
        r_end = '{unit: '0, status: end_st, run_last: 1'b1};

        emit_n = !emit_v ? 2'd0 : (pair ? 2'd2 : 2'd1);

        group.items    = {r_end, r_b, r_a};
        group.count    = emit_n + {1'b0, end_of_buffer};
        unique case (emit_n)
            2'd0:
            begin
                group.items[0] = r_end;
            end
            2'd1:
            begin
                group.items[1]          = r_end;
                group.items[0].run_last = !end_of_buffer;
            end
            2'd2:
            begin
                group.items[2]          = r_end;
                group.items[1].run_last = !end_of_buffer;
            end
            default:
            begin
                group.items[0] = r_end;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utf16_reg    <= 1'b0;
            skip_bom_reg <= 1'b0;
            acc_reg      <= '0;
            cont_reg     <= 2'd0;
            fail_reg     <= 1'b0;
            start_reg    <= 1'b1;
            bom_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == u8sd_pkg::REG_UTF16_OUTPUT)
                utf16_reg <= cfg_data[0];
            if (cfg_we && cfg_index == u8sd_pkg::REG_SKIP_BOM)
                skip_bom_reg <= cfg_data[0];
            if (take)
            begin
                acc_reg   <= acc_next;
                cont_reg  <= cont_next;
                fail_reg  <= fail_next;
                start_reg <= start_next;
                bom_reg   <= bom_next;
            end
        end
    end

endmodule

[design/u8sd_outq.sv]
// Four-entry result queue that takes up to three results a cycle while room is high.
`timescale 1ns / 1ps

module u8sd_outq (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  u8sd_pkg::result_group_t  group,
    output logic                     room,
    output logic                     out_valid,
    input  logic                     out_ready,
    output u8sd_pkg::result_t        out_item
);

    u8sd_pkg::result_t q_reg [4];
    logic [1:0]        wr_ptr_reg, wr_ptr_next;
    logic [1:0]        rd_ptr_reg, rd_ptr_next;
    logic [2:0]        count_reg,  count_next;
    logic [1:0]        push_n;
    logic              pop;

    assign push_n    = push ? group.count : 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 3'd0);
    assign out_item  = q_reg[rd_ptr_reg];
    assign room      = (count_reg <= 3'd1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_n} - {2'd0, pop};
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < u8sd_pkg::MAX_RES; k++)
        begin
            if (push && ({1'b0, 2'(k)} < {1'b0, group.count}))
                q_reg[wr_ptr_reg + 2'(k)] <= group.items[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[design/utf8_stream_decoder_unit.sv]
// Top level of the UTF-8 stream decoder.
`timescale 1ns / 1ps

// Decodes a UTF-8 byte stream into code points or UTF-16 units. One byte is
// taken per cycle while s_tready is high; each byte yields zero to three
// results (a unit, a surrogate pair, and an end-of-buffer status on the byte
// with tlast). The results drain one per cycle, while m_tready is high, from a
// four-entry output queue, and s_tready is high while at most one result
// waits there, so bytes that give one result each stream at one per cycle
// while m_tready holds high. Write configuration only while the block is idle.

module utf8_stream_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [0:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_buffer
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] unit, [23:21] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // run_last
);

    logic                    take;
    logic                    room;
    u8sd_pkg::result_group_t group;
    u8sd_pkg::result_t       item;

    assign s_tready = room;
    assign take     = s_tvalid && room;

    u8sd_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .take          (take),
        .data_byte     (s_tdata),
        .end_of_buffer (s_tlast),
        .group         (group)
    );

    u8sd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .group     (group),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (item)
    );

    assign m_tdata = {3'd0, item.unit};
    assign m_tuser = item.status;
    assign m_tlast = item.run_last;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the UTF-8 stream decoder: table-driven cases, then random buffers.
`timescale 1ns / 1ps

module tb_top;

    localparam int DIR_ROWS    = 26;
    localparam int NO_TYPED    = -1;
    localparam int PHASE_BYTES = 80;
    localparam int DRAIN_GAP   = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 4000;

    localparam int PRESS_NONE  = 0;
    localparam int PRESS_HOLD  = 1;
    localparam int PRESS_PAUSE = 2;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        logic        utf16;
        logic        skip;
        int          typed_n;
        logic [20:0] typed_unit;
        logic [1:0]  typed_status;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [0:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // [7:0] data_byte
    logic        s_tlast = 1'b0;  // end_of_buffer
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // [20:0] unit, [23:21] zero
    logic [1:0]  m_tuser;         // [1:0] status
    logic        m_tlast;         // run_last

    utf8_stream_decoder_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decoder mirror
    logic        pred_utf16 = 1'b0;
    logic        pred_skip_bom = 1'b0;
    logic [20:0] pred_acc = '0;
    logic [1:0]  pred_cont = '0;
    logic [1:0]  pred_fail = '0;
    logic        pred_start = 1'b1;
    logic        pred_bom = 1'b0;

    u8sd_pkg::result_t step_res [0:2];
    int                step_n;
    int                last_step_count;
    u8sd_pkg::result_t last_step_final;
    u8sd_pkg::result_t awaited_results [$];
    u8sd_pkg::result_t want_res;

    int err_count = 0;
    int bytes_in = 0;
    int buffers_in = 0;
    int results_out = 0;
    int quiet = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int phase_bytes = 0;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b0, 1'b0, 2,        21'h0,    u8sd_pkg::ST_END_OK},
        '{8'h7F, 1'b0, 1'b0, 1'b0, 1,        21'h7F,   u8sd_pkg::ST_UNIT},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 1,        21'h0,    u8sd_pkg::ST_UNIT},
        '{8'hF8, 1'b1, 1'b0, 1'b0, 2,        21'h0,    u8sd_pkg::ST_END_OK},
        '{8'hC3, 1'b0, 1'b0, 1'b0, 0,        21'h0,    u8sd_pkg::ST_UNIT},
        '{8'hA9, 1'b1, 1'b0, 1'b0, NO_TYPED, 21'h0,    u8sd_pkg::ST_UNIT},
        '{8'hE2, 1'b0, 1'b0, 1'b0, NO_TYPED, 21'h0,    u8sd_pkg::ST_UNIT},
        '{8'h82, 1'b0, 1'b0, 1'b0, NO_TYPED, 21'h0,    u8sd_pkg::ST_UNIT},
        '{8'hAC, 1'b0, 1'b0, 1'b0, 1,        21'h20AC, u8sd_pkg::ST_UNIT},
        '{8'h80, 1'b0, 1'b0, 1'b0, 0,        21'h0,    u8sd_pkg::ST_UNIT},
        '{8'h41, 1'b1, 1'b0, 1'b0, 1,        21'h0,    u8sd_pkg::ST_END_STRAY},
        '{8'hE2, 1'b0, 1'b0, 1'b0, NO_TYPED, 21'h0,    u8sd_pkg::ST_UNIT},
        '{8'h82, 1'b1, 1'b0, 1'b0, 1,        21'h0,    u8sd_pkg::ST_END_TRUNC},
        '{8'hEF, 1'b0, 1'b1, 1'b1, NO_TYPED, 21'h0,    u8sd_pkg::ST_UNIT},
        '{8'hBB, 1'b0, 1'b1, 1'b1, NO_TYPED, 21'h0,    u8sd_pkg::ST_UNIT},
        '{8'hBF, 1'b0, 1'b1, 1'b1, 0,        21'h0,    u8sd_pkg::ST_UNIT},
        '{8'h41, 1'b1, 1'b1, 1'b1, 2,        21'h0,    u8sd_pkg::ST_END_OK},
        '{8'hF7, 1'b0, 1'b1, 1'b1, NO_TYPED, 21'h0,    u8sd_pkg::ST_UNIT},
        '{8'hBF, 1'b0, 1'b1, 1'b1, NO_TYPED, 21'h0,    u8sd_pkg::ST_UNIT},
        '{8'hBF, 1'b0, 1'b1, 1'b1, NO_TYPED, 21'h0,    u8sd_pkg::ST_UNIT},
        '{8'hBF, 1'b1, 1'b1, 1'b1, 3,        21'h0,    u8sd_pkg::ST_END_OK},
        '{8'hEF, 1'b0, 1'b1, 1'b1, NO_TYPED, 21'h0,    u8sd_pkg::ST_UNIT},
        '{8'hBB, 1'b1, 1'b1, 1'b1, 1,        21'h0,    u8sd_pkg::ST_END_TRUNC},
        '{8'hEF, 1'b0, 1'b1, 1'b1, NO_TYPED, 21'h0,    u8sd_pkg::ST_UNIT},
        '{8'hBB, 1'b0, 1'b1, 1'b1, NO_TYPED, 21'h0,    u8sd_pkg::ST_UNIT},
        '{8'hBE, 1'b1, 1'b1, 1'b1, NO_TYPED, 21'h0,    u8sd_pkg::ST_UNIT}
    };

    task automatic report_fault(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void put_unit(input logic [20:0] u, input logic [1:0] st);
        step_res[step_n] = '{unit: u, status: st, run_last: 1'b0};
        step_n++;
    endfunction

    function automatic void emit_code(input logic [20:0] cp);
        logic [20:0] off;
        if (pred_utf16 && cp >= 21'h10000)
        begin
            off = cp - 21'h10000;
            put_unit({5'b0, u8sd_pkg::HI_SURR_BASE} + {11'b0, off[19:10]},
                     u8sd_pkg::ST_UNIT);
            put_unit({5'b0, u8sd_pkg::LO_SURR_BASE} + {11'b0, off[9:0]},
                     u8sd_pkg::ST_UNIT);
        end
        else
            put_unit(cp, u8sd_pkg::ST_UNIT);
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eob);
        logic       first;
        logic [7:0] want;
        step_n = 0;
        first = pred_start;
        pred_start = 1'b0;
        if (pred_fail != 2'b00)
        begin
            // buffer already failed, byte dropped
        end
        else if (pred_cont != 2'd0)
        begin
            if (pred_bom)
            begin
                want = (pred_cont == 2'd2) ? u8sd_pkg::BOM_B1 : u8sd_pkg::BOM_B2;
                if (b != want)
                    pred_bom = 1'b0;
            end
            pred_acc = {pred_acc[14:0], b[5:0]};
            pred_cont = pred_cont - 2'd1;
            if (pred_cont == 2'd0)
            begin
                if (!pred_bom)
                    emit_code(pred_acc);
                pred_bom = 1'b0;
                pred_acc = '0;
            end
        end
        else if (!b[7])
            emit_code({13'b0, b});
        else if (b[7:6] == 2'b10)
            pred_fail = u8sd_pkg::ST_END_STRAY;
        else if (b[7:5] == 3'b110)
        begin
            pred_acc = {16'b0, b[4:0]};
            pred_cont = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            pred_acc = {17'b0, b[3:0]};
            pred_cont = 2'd2;
            pred_bom = first && pred_skip_bom && (b == u8sd_pkg::BOM_B0);
        end
        else if (b[7:3] == 5'b11110)
        begin
            pred_acc = {18'b0, b[2:0]};
            pred_cont = 2'd3;
        end
        else
            emit_code('0);

        if (eob)
        begin
            if (pred_fail != 2'b00)
                put_unit('0, u8sd_pkg::ST_END_STRAY);
            else if (pred_cont != 2'd0)
                put_unit('0, u8sd_pkg::ST_END_TRUNC);
            else
                put_unit('0, u8sd_pkg::ST_END_OK);
            pred_acc = '0;
            pred_cont = '0;
            pred_fail = '0;
            pred_start = 1'b1;
            pred_bom = 1'b0;
        end

        if (step_n > 0)
            step_res[step_n-1].run_last = 1'b1;
        for (int i = 0; i < step_n; i++)
            awaited_results.insert(awaited_results.size(), step_res[i]);
        last_step_count = step_n;
        if (step_n > 0)
            last_step_final = step_res[step_n-1];
    endfunction

    // predict on input transfers, check output transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                decode_byte(s_tdata, s_tlast);
                bytes_in++;
                if (s_tlast)
                    buffers_in++;
            end
            if (m_tvalid && m_tready)
            begin
                if (awaited_results.size() == 0)
                    report_fault($sformatf("unexpected result: unit %0h status %0d",
                                           m_tdata, m_tuser));
                else
                begin
                    want_res = awaited_results.pop_front();
                    results_out++;
                    if (m_tdata !== {3'b000, want_res.unit})
                        report_fault($sformatf("unit: got %0h want %0h",
                                               m_tdata, want_res.unit));
                    if (m_tuser !== want_res.status)
                        report_fault($sformatf("status: got %0d want %0d",
                                               m_tuser, want_res.status));
                    if (m_tlast !== want_res.run_last)
                        report_fault($sformatf("run_last: got %0b want %0b",
                                               m_tlast, want_res.run_last));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        while (quiet < QUIET_LIMIT)
            @(posedge clk);
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("utf8_stream_decoder_unit verification failed");
        $finish;
    end

    // all stimulus tasks start and end at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        phase_bytes++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_GAP) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == u8sd_pkg::REG_UTF16_OUTPUT)
            pred_utf16 = val;
        else
            pred_skip_bom = val;
    endtask

    task automatic set_mode(input logic utf16, input logic skip);
        wait_drained();
        write_reg(u8sd_pkg::REG_UTF16_OUTPUT, utf16);
        write_reg(u8sd_pkg::REG_SKIP_BOM, skip);
    endtask

    task automatic send_buffer();
        logic [7:0] bq [$];
        int nchars;
        int k;
        int r;
        nchars = $urandom_range(1, 6);
        if ($urandom_range(0, 3) == 0)
        begin
            bq.insert(bq.size(), u8sd_pkg::BOM_B0);
            bq.insert(bq.size(), u8sd_pkg::BOM_B1);
            if ($urandom_range(0, 1) == 0)
                bq.insert(bq.size(), u8sd_pkg::BOM_B2);
            else
                bq.insert(bq.size(), 8'h80 | 8'($urandom_range(0, 63)));
        end
        for (int c = 0; c < nchars; c++)
        begin
            r = $urandom_range(0, 99);
            k = 0;
            if (r < 35)
                bq.insert(bq.size(), 8'($urandom_range(0, 127)));
            else if (r < 55)
            begin
                bq.insert(bq.size(), 8'hC0 | 8'($urandom_range(0, 31)));
                k = 1;
            end
            else if (r < 72)
            begin
                bq.insert(bq.size(), 8'hE0 | 8'($urandom_range(0, 15)));
                k = 2;
            end
            else if (r < 87)
            begin
                bq.insert(bq.size(), 8'hF0 | 8'($urandom_range(0, 7)));
                k = 3;
            end
            else if (r < 92)
                bq.insert(bq.size(), 8'($urandom_range(248, 255)));
            else if (r < 96)
                bq.insert(bq.size(), 8'($urandom_range(128, 191)));
            else
                bq.insert(bq.size(), 8'($urandom_range(0, 255)));
            // sometimes cut the final sequence short
            if (k > 0 && c == nchars - 1 && $urandom_range(0, 7) == 0)
                k = $urandom_range(0, k - 1);
            repeat (k) bq.insert(bq.size(), 8'h80 | 8'($urandom_range(0, 63)));
        end
        for (int i = 0; i < bq.size(); i++)
            send_byte(bq[i], i == bq.size() - 1);
    endtask

    task automatic run_phase(input logic utf16, input logic skip, input int s_idle,
                             input int r_idle, input int press);
        logic pressed;
        set_mode(utf16, skip);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        phase_bytes = 0;
        pressed = 1'b0;
        while (phase_bytes < PHASE_BYTES)
        begin
            if (!pressed && phase_bytes >= PHASE_BYTES / 2)
            begin
                pressed = 1'b1;
                if (press == PRESS_HOLD)
                    hold_requests++;
                else if (press == PRESS_PAUSE)
                    wait_drained();
            end
            send_buffer();
        end
    endtask

    initial
    begin
        send_idle_pct = 17;
        recv_idle_pct = 65;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_table[i].utf16 != pred_utf16 || dir_table[i].skip != pred_skip_bom)
                set_mode(dir_table[i].utf16, dir_table[i].skip);
            send_byte(dir_table[i].data, dir_table[i].last);
            if (dir_table[i].typed_n != NO_TYPED)
            begin
                if (last_step_count != dir_table[i].typed_n)
                    report_fault($sformatf("row %0d: %0d results predicted, table says %0d",
                                           i, last_step_count, dir_table[i].typed_n));
                else if (last_step_count > 0 &&
                         (last_step_final.unit != dir_table[i].typed_unit ||
                          last_step_final.status != dir_table[i].typed_status))
                    report_fault($sformatf("row %0d: final result %0h/%0d, table says %0h/%0d",
                                           i, last_step_final.unit, last_step_final.status,
                                           dir_table[i].typed_unit,
                                           dir_table[i].typed_status));
            end
        end

        run_phase(1'b1, 1'b0, 17, 65, PRESS_NONE);
        run_phase(1'b0, 1'b1, 17, 65, PRESS_NONE);
        run_phase(1'b1, 1'b1, 65, 17, PRESS_HOLD);
        run_phase(1'b0, 1'b0, 65, 17, PRESS_NONE);
        run_phase(1'b1, 1'b1, 0, 0, PRESS_NONE);
        run_phase(1'b0, 1'b1, 0, 0, PRESS_PAUSE);
        wait_drained();

        $display("checked %0d bytes in %0d buffers against %0d decoded results",
                 bytes_in, buffers_in, results_out);
        $display("both output modes, both BOM settings, long output stall and input pause");
        if (err_count == 0)
            $display("utf8_stream_decoder_unit verification clean");
        else
            $display("utf8_stream_decoder_unit verification failed");
        $finish;
    end

endmodule
